>>> src/bkr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkr_pkg
// Shared types, constants and the button index remap for the keyboard
// report block.
// ----------------------------------------------------------------------------
package bkr_pkg;

  localparam int NUM_KEYS_DEF        = 12;
  localparam int MAX_REPORT_KEYS_DEF = 6;

  localparam int SLOT_COUNT = 6;
  localparam int MAP_SIZE   = 12;
  localparam int LIM_W      = 5;   // holds the largest key count, 15, with a spare bit

  localparam logic [7:0] GUI_KEYCODE  = 8'hE3;
  localparam logic [7:0] GUI_MOD_BIT  = 8'h08;
  localparam logic [3:0] ACTIVE_RESET = 4'd12;

  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_ASSIGN = 1'b1;

  typedef struct packed {
    logic [7:0] new_keycode;
    logic [7:0] new_modifier;
    logic [7:0] button_number;
    logic [11:0] buttons;
    logic        action;
  } in_item_t;

  typedef struct packed {
    logic                           rejected;
    logic [SLOT_COUNT-1:0][7:0]     keys;
    logic [7:0]                     modifier;
  } result_t;

  // row-major host numbering to column-major table index
  function automatic logic [3:0] remap(input logic [3:0] num);
    logic [3:0] idx;
    unique case (num)
      4'd0:    idx = 4'd0;
      4'd1:    idx = 4'd3;
      4'd2:    idx = 4'd6;
      4'd3:    idx = 4'd9;
      4'd4:    idx = 4'd1;
      4'd5:    idx = 4'd4;
      4'd6:    idx = 4'd7;
      4'd7:    idx = 4'd10;
      4'd8:    idx = 4'd2;
      4'd9:    idx = 4'd5;
      4'd10:   idx = 4'd8;
      4'd11:   idx = 4'd11;
      default: idx = 4'd0;
    endcase
    return idx;
  endfunction

endpackage

>>> src/button_mask_to_hid_keyboard_report_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_mask_to_hid_keyboard_report_top
// Builds 6-key keyboard reports from a pressed-button mask using a writable
// key assignment table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel. s_tuser selects the operation: a
//   report request scans the button mask over the key table, an assign
//   request stores a modifier and keycode for one host button number.
//   Each request gives exactly one result on the m_ channel.
//   A report request reads the table one entry per cycle over the first
//   min(active_buttons, NUM_KEYS) entries and then has its result ready;
//   an assign request goes straight to its result. One request is in
//   work at a time; s_tready rises again as soon as its result moves into
//   the output register. A result waiting in the output register does
//   not stop the next request: only when a second result is ready while
//   the first is still held does the block wait, with s_tready low, until
//   m_tready. Reset clears the table (through per-entry valid bits),
//   sets active_buttons to 12 and empties the output register. The user
//   must write active_buttons with cfg_we only while the block is idle;
//   the block itself does not enforce this.
// ----------------------------------------------------------------------------
module button_mask_to_hid_keyboard_report_top
  import bkr_pkg::*;
#(
  parameter int NUM_KEYS        = NUM_KEYS_DEF,
  parameter int MAX_REPORT_KEYS = MAX_REPORT_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // buttons[11:0], button_number[19:12], new_modifier[27:20],
  // new_keycode[35:28], zero[39:36]
  input  logic [39:0] s_tdata,
  // action[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // report_modifier[7:0], key_one[15:8], key_two[23:16], key_three[31:24],
  // key_four[39:32], key_five[47:40], key_six[55:48]
  output logic [55:0] m_tdata,
  // assign_rejected[0]
  output logic [0:0]  m_tuser
);

  logic [3:0] active_buttons;
  in_item_t   item;
  result_t    res;
  logic       res_valid;
  logic       res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_buttons <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_buttons <= cfg_wdata;
    end
  end

  assign item.action        = s_tuser[0];
  assign item.buttons       = s_tdata[11:0];
  assign item.button_number = s_tdata[19:12];
  assign item.new_modifier  = s_tdata[27:20];
  assign item.new_keycode   = s_tdata[35:28];

  bkr_engine #(
    .NUM_KEYS        (NUM_KEYS),
    .MAX_REPORT_KEYS (MAX_REPORT_KEYS)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .item_valid     (s_tvalid),
    .item_ready     (s_tready),
    .active_buttons (active_buttons),
    .res            (res),
    .res_valid      (res_valid),
    .res_take       (res_take)
  );

  assign res_take = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      m_tdata <= {res.keys, res.modifier};
      m_tuser <= res.rejected;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while previous one still in work");

  a_reject_is_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 56'h0)
    else $error("rejected assign carries report data");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_take |=> m_tvalid)
    else $error("finished result not presented");

  a_ready_excl_done: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !res_valid)
    else $error("ready while a result is pending");
`endif

endmodule

>>> src/bkr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bkr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/bkr_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkr_engine
// Key table sequencer: writes assignments and walks the table one entry
// per cycle to build a report.
// ----------------------------------------------------------------------------
module bkr_engine
  import bkr_pkg::*;
#(
  parameter int NUM_KEYS        = NUM_KEYS_DEF,
  parameter int MAX_REPORT_KEYS = MAX_REPORT_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   item,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [3:0] active_buttons,
  output result_t    res,
  output logic       res_valid,
  input  logic       res_take
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CNT_W = $clog2(NUM_KEYS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    limit;
  logic [NUM_KEYS-1:0] mask;
  logic [NUM_KEYS-1:0] valid;
  logic                pend;
  logic                hit_q;
  logic [IDX_W-1:0]    idx_q;
  logic [2:0]          used;

  logic             accept;
  logic [3:0]       remap_idx;
  logic             wr_ok;
  logic [7:0]       wr_mod;
  logic [7:0]       wr_kc;
  logic             we;
  logic             issue;
  logic [15:0]      rdata;
  logic [15:0]      entry;
  logic             take;
  logic [LIM_W-1:0] lim_full;

  assign item_ready = (state == ST_IDLE);
  assign res_valid  = (state == ST_DONE);
  assign accept     = item_valid && item_ready;

  assign remap_idx = remap(item.button_number[3:0]);
  assign wr_ok     = (item.button_number < 8'(MAP_SIZE)) &&
                     ({1'b0, remap_idx} < LIM_W'(NUM_KEYS));

  // the gui keycode is folded into the modifier byte
  always_comb begin
    wr_mod = item.new_modifier;
    wr_kc  = item.new_keycode;
    if (item.new_keycode == GUI_KEYCODE) begin
      wr_mod = item.new_modifier | GUI_MOD_BIT;
      wr_kc  = 8'h00;
    end
  end

  assign we = accept && (item.action == ACT_ASSIGN) && wr_ok;

  assign lim_full = ({1'b0, active_buttons} > LIM_W'(NUM_KEYS)) ?
                    LIM_W'(NUM_KEYS) : {1'b0, active_buttons};

  assign issue = (state == ST_SCAN) && (cnt < limit);

  bkr_ram #(
    .WIDTH (16),
    .DEPTH (NUM_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (remap_idx[IDX_W-1:0]),
    .wdata ({wr_mod, wr_kc}),
    .re    (issue),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  // entries never written since reset read as zero
  assign entry = valid[idx_q] ? rdata : 16'h0000;
  assign take  = pend && hit_q && (used < 3'(MAX_REPORT_KEYS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      pend  <= 1'b0;
    end else begin
      pend <= issue;
      if (we) begin
        valid[remap_idx[IDX_W-1:0]] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (item.action == ACT_ASSIGN) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!issue && !pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt          <= '0;
      limit        <= lim_full[CNT_W-1:0];
      mask         <= NUM_KEYS'(item.buttons);
      used         <= 3'd0;
      res.modifier <= 8'h00;
      res.keys     <= '0;
      res.rejected <= (item.action == ACT_ASSIGN) && !wr_ok;
    end else begin
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (take) begin
        res.keys[used] <= entry[7:0];
        res.modifier   <= res.modifier | entry[15:8];
        used           <= used + 3'd1;
      end
    end
    hit_q <= mask[cnt[IDX_W-1:0]];
    idx_q <= cnt[IDX_W-1:0];
  end

endmodule

>>> bench/button_mask_to_hid_keyboard_report_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_mask_to_hid_keyboard_report_top_tb
// Drives report and assign requests with random idling on both sides,
// rewrites active_buttons between phases, and checks every result field
// against a key table predictor kept alongside the block.
// ----------------------------------------------------------------------------
module button_mask_to_hid_keyboard_report_top_tb
  import bkr_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_REQUESTS = 130;
  localparam int HOLD_CYCLES    = 400;

  class hid_report_board;
    logic [15:0] key_table [NUM_KEYS_DEF];
    logic [3:0]  active_buttons;
    result_t     expected_reports [$];
    int          mismatches;

    function new();
      foreach (key_table[i]) key_table[i] = 16'h0000;
      active_buttons = ACTIVE_RESET;
      mismatches     = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // fields: buttons[11:0], button_number[19:12], modifier[27:20], keycode[35:28]
    function void note_request(logic act, logic [35:0] fields);
      logic [11:0] mask;
      logic [7:0]  num;
      logic [7:0]  mod;
      logic [7:0]  key;
      result_t     want;
      int          lim;
      int          used;
      int          idx;
      {key, mod, num, mask} = fields;
      want = '0;
      if (act == ACT_REPORT) begin
        lim  = (active_buttons > NUM_KEYS_DEF) ? NUM_KEYS_DEF : int'(active_buttons);
        used = 0;
        for (int i = 0; i < lim; i++) begin
          if (mask[i] && used < MAX_REPORT_KEYS_DEF) begin
            want.keys[used] = key_table[i][7:0];
            want.modifier   = want.modifier | key_table[i][15:8];
            used++;
          end
        end
      end else if (num >= MAP_SIZE) begin
        want.rejected = 1'b1;
      end else begin
        // host numbers run along rows of four, the table runs down columns of three
        idx = (int'(num) % 4) * 3 + int'(num) / 4;
        if (key == GUI_KEYCODE) begin
          mod = mod | GUI_MOD_BIT;
          key = 8'h00;
        end
        key_table[idx] = {mod, key};
      end
      expected_reports.push_back(want);
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.modifier !== want.modifier) begin
        $display("%0t: report_modifier expected %h got %h", $time, want.modifier,
                 got.modifier);
        mismatches++;
      end
      for (int s = 0; s < SLOT_COUNT; s++) begin
        if (got.keys[s] !== want.keys[s]) begin
          $display("%0t: key slot %0d expected %h got %h", $time, s, want.keys[s],
                   got.keys[s]);
          mismatches++;
        end
      end
      if (got.rejected !== want.rejected) begin
        $display("%0t: assign_rejected expected %b got %b", $time, want.rejected,
                 got.rejected);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;

  hid_report_board sb;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  int phase_active [15] = '{12, 0, 15, 5, 1, 13, 12, 9, 14, 11, 3, 12, 0, 15, 7};

  button_mask_to_hid_keyboard_report_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done  <= 1'b1;
      stall_left <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_report(result_t'({m_tuser, m_tdata}));
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(input logic act, input logic [35:0] fields);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0000, fields};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(act, fields);
  endtask

  task automatic drain_requests();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_active(input logic [3:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.active_buttons = value;
  endtask

  task automatic random_request();
    logic [11:0] mask;
    logic [7:0]  num;
    logic [7:0]  mod;
    logic [7:0]  key;
    if ($urandom_range(99) < 30) begin
      num = ($urandom_range(99) < 88) ? 8'($urandom_range(11)) : 8'($urandom_range(255, 12));
      mod = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
      key = ($urandom_range(9) == 0) ? GUI_KEYCODE : 8'($urandom);
      send_request(ACT_ASSIGN, {key, mod, num, 12'($urandom)});
    end else begin
      case ($urandom_range(2))
        0: mask = 12'($urandom);
        1: mask = 12'($urandom & $urandom & $urandom);
        default: mask = 12'(1 << $urandom_range(11));
      endcase
      send_request(ACT_REPORT, {8'($urandom), 8'($urandom), 8'($urandom), mask});
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table, then fill a few entries with extreme values
    send_request(ACT_REPORT, {8'h00, 8'h00, 8'h00, 12'hFFF});
    send_request(ACT_ASSIGN, {8'hFF, 8'h00, 8'd0, 12'h000});
    send_request(ACT_ASSIGN, {8'h01, 8'hFF, 8'd11, 12'hFFF});
    send_request(ACT_ASSIGN, {GUI_KEYCODE, 8'h01, 8'd5, 12'h000});
    send_request(ACT_ASSIGN, {GUI_KEYCODE, 8'h80, 8'd7, 12'h000});
    send_request(ACT_ASSIGN, {8'h04, 8'h02, 8'd3, 12'h000});
    send_request(ACT_ASSIGN, {8'h2A, 8'h40, 8'd8, 12'h000});
    send_request(ACT_ASSIGN, {8'h3B, 8'h10, 8'd1, 12'h000});
    // out-of-range button numbers leave the table alone
    send_request(ACT_ASSIGN, {8'h55, 8'h55, 8'd12, 12'h000});
    send_request(ACT_ASSIGN, {8'hAA, 8'hAA, 8'd255, 12'hFFF});
    send_request(ACT_ASSIGN, {8'hFF, 8'hFF, 8'd128, 12'h000});
    // more than six pressed keys, none, single ends, exactly six, seven
    send_request(ACT_REPORT, {8'hFF, 8'hFF, 8'hFF, 12'hFFF});
    send_request(ACT_REPORT, {8'h00, 8'h00, 8'h00, 12'h000});
    send_request(ACT_REPORT, {8'h00, 8'h00, 8'h00, 12'h001});
    send_request(ACT_REPORT, {8'h00, 8'h00, 8'h00, 12'h800});
    send_request(ACT_REPORT, {8'h00, 8'h00, 8'h00, 12'hAAA});
    send_request(ACT_REPORT, {8'h00, 8'h00, 8'h00, 12'h7F0});
    send_request(ACT_REPORT, {8'h00, 8'h00, 8'h00, 12'h555});

    for (int b = 0; b < 15; b++) begin
      drain_requests();
      set_active(4'(phase_active[b]));
      if (b < 5) begin
        src_idle_pct = 32;
        snk_idle_pct = 69;
      end else if (b < 10) begin
        src_idle_pct = 69;
        snk_idle_pct = 32;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      // long receiver stall while the sender keeps offering
      if (b == 10) hold_go = 1'b1;
      repeat (PHASE_REQUESTS) random_request();
    end

    drain_requests();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
